// ----- sv/pemsc_pkg.sv -----
// Package for the paste end marker scanner.
// Holds the marker table, the hand-over descriptor type and the result decode function.
// Depends on nothing; the scan, emit and core files refer to it by scoped names.
package pemsc_pkg;

  localparam logic [2:0] MARK_LEN  = 3'd6;
  localparam logic [2:0] MARK_LAST = 3'd5;
  localparam logic [7:0] ESC_BYTE  = 8'h1B;

  // What follows the replayed marker prefix in the results of one input byte.
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_TEXT = 2'd1,
    TAIL_END  = 2'd2
  } tail_t;

  // One input byte's results in compact form: a replayed prefix of plen marker
  // bytes, followed by an optional text byte or paste end result.
  typedef struct packed {
    logic [2:0] plen;
    tail_t      tail;
    logic [7:0] data;
  } desc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } result_t;

  function automatic logic [7:0] mark_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h1B;
      3'd1:    b = 8'h5B;
      3'd2:    b = 8'h32;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h31;
      3'd5:    b = 8'h7E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Result number idx of a descriptor.
  function automatic result_t desc_result(input desc_t d, input logic [2:0] idx);
    result_t r;
    if (idx < d.plen) begin
      r.data = mark_byte(idx);
      r.kind = 1'b0;
      r.last = (idx == d.plen - 3'd1) && (d.tail == TAIL_NONE);
    end else if (d.tail == TAIL_END) begin
      r.data = 8'h00;
      r.kind = 1'b1;
      r.last = 1'b1;
    end else begin
      r.data = d.data;
      r.kind = 1'b0;
      r.last = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- sv/pemsc_scan.sv -----
// Input stage of the paste end marker scanner: match counter and descriptor register.
// Uses pemsc_pkg for the marker table and the descriptor type.
module pemsc_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  output logic                desc_valid,
  output pemsc_pkg::desc_t    desc,
  input  logic                desc_take
);

  logic [2:0]       match_count_r, match_count_nxt;
  logic             desc_valid_r;
  pemsc_pkg::desc_t desc_r, desc_nxt;
  logic             has_result;
  logic             in_fire;
  logic [2:0]       held;

  assign in_stall   = desc_valid_r && !desc_take;
  assign in_fire    = in_valid && !in_stall;
  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

  always_comb begin
    held            = (match_count_r > pemsc_pkg::MARK_LAST) ? 3'd0 : match_count_r;
    has_result      = 1'b0;
    match_count_nxt = 3'd0;
    desc_nxt.plen   = 3'd0;
    desc_nxt.tail   = pemsc_pkg::TAIL_NONE;
    desc_nxt.data   = in_data_byte;
    if (in_data_byte == pemsc_pkg::mark_byte(held)) begin
      if (held == pemsc_pkg::MARK_LAST) begin
        has_result    = 1'b1;
        desc_nxt.tail = pemsc_pkg::TAIL_END;
      end else begin
        match_count_nxt = held + 3'd1;
      end
    end else begin
      // A break: the held prefix is replayed. An ESC starts a fresh match.
      has_result    = 1'b1;
      desc_nxt.plen = held;
      if (in_data_byte == pemsc_pkg::ESC_BYTE) begin
        match_count_nxt = 3'd1;
      end else begin
        desc_nxt.tail = pemsc_pkg::TAIL_TEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_count_r <= 3'd0;
      desc_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        match_count_r <= match_count_nxt;
        desc_valid_r  <= has_result;
      end else if (desc_take) begin
        desc_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

// ----- sv/pemsc_emit.sv -----
// Output stage of the paste end marker scanner: unrolls descriptors into results.
// Uses pemsc_pkg for the descriptor type and the result decode function.
module pemsc_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             desc_valid,
  input  pemsc_pkg::desc_t desc,
  output logic             desc_take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_out_byte,
  output logic             out_kind,
  output logic             out_last
);

  logic                 cur_valid_r;
  pemsc_pkg::desc_t     cur_r;
  logic [2:0]           idx_r;
  logic                 out_valid_r;
  pemsc_pkg::result_t   res_r;

  pemsc_pkg::desc_t     src;
  logic [2:0]           src_idx;
  logic                 src_valid;
  logic                 adv;
  pemsc_pkg::result_t   res_nxt;

  // The descriptor being unrolled wins; a fresh one starts at its first result.
  assign src       = cur_valid_r ? cur_r : desc;
  assign src_idx   = cur_valid_r ? idx_r : 3'd0;
  assign src_valid = cur_valid_r || desc_valid;
  assign adv       = !out_valid_r || !out_stall;
  assign desc_take = !cur_valid_r && desc_valid && adv;
  assign res_nxt   = pemsc_pkg::desc_result(src, src_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= src_valid;
      if (src_valid) begin
        cur_valid_r <= !res_nxt.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && src_valid) begin
      res_r <= res_nxt;
      cur_r <= src;
      idx_r <= src_idx + 3'd1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_out_byte = res_r.data;
  assign out_kind     = res_r.kind;
  assign out_last     = res_r.last;

endmodule

// ----- sv/paste_end_marker_scanner_core.sv -----
// Paste end marker scanner. Bytes of a terminal paste enter one per transfer
// and are searched for the end marker ESC [ 2 0 1 ~. Bytes that may start or
// extend the marker are held back; when the marker completes a single result
// with kind 1 is given, and when a match breaks the held bytes are replayed as
// text, followed by the breaking byte unless it is an ESC that opens a new
// match. Every result carries one byte, and the last result of an input byte
// has last set. An input byte is accepted in every cycle while each one yields
// at most one result and out_stall stays low; a byte that yields n results (up
// to six) occupies the single-result output register for each of them in turn,
// so the sustained rate is one result per cycle while out_stall is low. One
// descriptor register between the scanning stage and the output stage lets the
// next byte be taken while a result still waits to be transferred. The first
// result of a byte passes through the descriptor register and then the output
// register before it is presented.
// Uses pemsc_pkg, pemsc_scan and pemsc_emit.
module paste_end_marker_scanner_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_kind,
  output logic       out_last
);

  // Hand-over between the scanning stage and the output stage.
  logic             desc_valid;
  logic             desc_take;
  pemsc_pkg::desc_t desc;

  pemsc_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .desc_valid   (desc_valid),
    .desc         (desc),
    .desc_take    (desc_take)
  );

  pemsc_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .desc_valid   (desc_valid),
    .desc         (desc),
    .desc_take    (desc_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_out_byte (out_out_byte),
    .out_kind     (out_kind),
    .out_last     (out_last)
  );

endmodule

// ----- sv/pemsc_checker.sv -----
// Port-level checks for the paste end marker scanner.
// Depends only on the ports of paste_end_marker_scanner_core; bound to it below.
module pemsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_out_byte,
  input logic       out_kind,
  input logic       out_last
);

  // A stalled input byte is held by the sender until it is transferred.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte))
    else $error("stalled input byte changed");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte)
      && $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  // A paste end result carries a zero byte and closes its input byte.
  a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last && out_out_byte == 8'h00)
    else $error("malformed paste end result");

  // The results of one input byte follow each other without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && !out_kind)
    else $error("gap inside the results of one byte");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind paste_end_marker_scanner_core pemsc_checker u_pemsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_data_byte (in_data_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_out_byte (out_out_byte),
  .out_kind     (out_kind),
  .out_last     (out_last)
);
